FILE: rtl/core/hpc_pkg.sv
// Shared types, constants and config register codes for the heading PI controller.
`default_nettype none
package hpc_pkg;

    localparam int WIN_LEN   = 12;
    localparam int POS_W     = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int HEAD_W    = 12;
    localparam int ERR_W     = 12;
    localparam int HALF_TURN = 1800;
    localparam int FULL_TURN = 3600;
    localparam int SUM_W     = $clog2(WIN_LEN * HALF_TURN + 1) + 1;
    localparam int DRIVE_W   = (SUM_W > ERR_W) ? SUM_W : ERR_W;
    localparam int SUM_SHIFT = 5;
    localparam int P_GAIN    = 3;
    localparam int RECIP_10  = 6554;
    localparam int RECIP_SH  = 16;

    localparam int DB_W      = 11;
    localparam int SPD_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;
    localparam int TURN_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd2;

    localparam logic [DB_W-1:0]  DEADBAND_RST  = 11'd10;
    localparam logic [SPD_W-1:0] MIN_SPEED_RST = 7'd10;
    localparam logic [SPD_W-1:0] MAX_SPEED_RST = 7'd70;

    typedef logic [HEAD_W-1:0]         heading_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [DRIVE_W-1:0] drive_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic signed [TURN_W-1:0]  turn_t;

    typedef struct packed {
        logic [DB_W-1:0]  deadband;
        logic [SPD_W-1:0] min_speed;
        logic [SPD_W-1:0] max_speed;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/hpc_if.sv
// Handshake channel interfaces for heading input, turn output and config writes.
`default_nettype none
interface hpc_heading_if;
    logic               valid;
    logic               ready;
    hpc_pkg::heading_t  target_heading;
    hpc_pkg::heading_t  measured_heading;

    modport source (output valid, output target_heading, output measured_heading,
                    input ready);
    modport sink   (input valid, input target_heading, input measured_heading,
                    output ready);
endinterface

interface hpc_turn_if;
    logic           valid;
    logic           ready;
    hpc_pkg::turn_t turn_rate;

    modport source (output valid, output turn_rate, input ready);
    modport sink   (input valid, input turn_rate, output ready);
endinterface

interface hpc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hpc_pkg::CFG_IDX_W-1:0]     index;
    logic [hpc_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hpc_shaper.sv
// Drive computation: proportional and integral terms, deadband and speed limits.
`default_nettype none
module hpc_shaper (
    input  hpc_pkg::err_t  err,
    input  hpc_pkg::sum_t  sum,
    input  hpc_pkg::cfg_t  cfg,
    output hpc_pkg::turn_t turn_rate
);
    import hpc_pkg::*;

    localparam int P3_W  = ERR_W + 1;
    localparam int PR_W  = P3_W + RECIP_SH;

    logic [ERR_W-1:0]   abs_err;
    logic [P3_W-1:0]    p3;
    logic [PR_W-1:0]    recip_prod;
    logic [P3_W-1:0]    p_mag;
    drive_t             p_term;
    sum_t               sum_adj;
    drive_t             i_term;
    drive_t             drive;
    logic [DRIVE_W-1:0] mag;
    logic [DRIVE_W-1:0] mag_min;
    logic [DRIVE_W-1:0] mag_max;
    logic [DRIVE_W-1:0] min_ext;
    logic [DRIVE_W-1:0] max_ext;
    logic [SPD_W-1:0]   mag_out;
    logic               outside;

    always_comb
    begin
        abs_err    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        p3         = P3_W'(abs_err) * P3_W'(P_GAIN);
        recip_prod = PR_W'(p3) * PR_W'(RECIP_10);
        p_mag      = P3_W'(recip_prod >> RECIP_SH);
        p_term     = err[ERR_W-1] ? -drive_t'(p_mag) : drive_t'(p_mag);

        sum_adj    = sum[SUM_W-1] ? sum + sum_t'((1 << SUM_SHIFT) - 1) : sum;
        i_term     = drive_t'(sum_adj >>> SUM_SHIFT);

        drive      = p_term + i_term;
        mag        = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
        min_ext    = DRIVE_W'(cfg.min_speed);
        max_ext    = DRIVE_W'(cfg.max_speed);

        mag_min    = (mag != '0 && mag < min_ext) ? min_ext : mag;
        mag_max    = (mag_min > max_ext) ? max_ext : mag_min;
        mag_out    = mag_max[SPD_W-1:0];

        outside    = abs_err >= ERR_W'(cfg.deadband);

        if (!outside)
        begin
            turn_rate = '0;
        end
        else if (drive[DRIVE_W-1])
        begin
            turn_rate = -turn_t'({1'b0, mag_out});
        end
        else
        begin
            turn_rate = turn_t'({1'b0, mag_out});
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/heading_pi_controller_unit.sv
// Top level of the heading PI controller with a moving-window integral.
// Each heading beat yields one turn_rate beat. A beat can be taken every
// cycle unless turn.ready stalls; stage 1 feeds stage 2. The first
// stage wraps the heading error into -1800..1800 and updates a 12-entry
// error ring together with a running sum of the ring; the second stage
// forms error*3/10 + sum/32 (truncated toward zero), applies the deadband
// and the min/max speed limits, and holds the result in the output
// register. Reset clears the ring and loads deadband 10, min_speed 10,
// max_speed 70. Config writes (index 0 deadband, 1 min_speed, 2 max_speed)
// are always accepted and should be issued only while the block is idle.
`default_nettype none
module heading_pi_controller_unit (
    input  wire            clk,
    input  wire            rst_n,
    hpc_heading_if.sink    heading,
    hpc_turn_if.source     turn,
    hpc_cfg_if.sink        cfg
);
    import hpc_pkg::*;

    cfg_t  cfg_reg;
    err_t  win_reg [WIN_LEN];
    pos_t  pos_reg;
    pos_t  pos_next;
    sum_t  run_sum_reg;
    sum_t  run_sum_next;
    err_t  err_next;
    err_t  s1_err_reg;
    sum_t  s1_sum_reg;
    logic  s1_valid_reg;
    turn_t turn_next;
    turn_t turn_reg;
    logic  turn_valid_reg;

    logic  in_fire;
    logic  advance;
    logic signed [ERR_W:0] diff;

    assign advance       = !turn_valid_reg || turn.ready;
    assign heading.ready = !s1_valid_reg || advance;
    assign in_fire       = heading.valid && heading.ready;
    assign cfg.ready     = 1'b1;
    assign turn.valid    = turn_valid_reg;
    assign turn.turn_rate = turn_reg;

    always_comb
    begin
        diff = $signed({1'b0, heading.target_heading})
             - $signed({1'b0, heading.measured_heading});
        if (diff > (ERR_W+1)'(HALF_TURN))
        begin
            err_next = err_t'(diff - (ERR_W+1)'(FULL_TURN));
        end
        else if (diff < -(ERR_W+1)'(HALF_TURN))
        begin
            err_next = err_t'(diff + (ERR_W+1)'(FULL_TURN));
        end
        else
        begin
            err_next = err_t'(diff);
        end
        run_sum_next = run_sum_reg - sum_t'(win_reg[pos_reg]) + sum_t'(err_next);
        pos_next     = (pos_reg == pos_t'(WIN_LEN - 1)) ? '0 : pos_reg + pos_t'(1);
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband  <= DEADBAND_RST;
            cfg_reg.min_speed <= MIN_SPEED_RST;
            cfg_reg.max_speed <= MAX_SPEED_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_DEADBAND:  cfg_reg.deadband  <= cfg.data[DB_W-1:0];
                CFG_MIN_SPEED: cfg_reg.min_speed <= cfg.data[SPD_W-1:0];
                CFG_MAX_SPEED: cfg_reg.max_speed <= cfg.data[SPD_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // error ring and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
            pos_reg     <= '0;
            run_sum_reg <= '0;
        end
        else if (in_fire)
        begin
            win_reg[pos_reg] <= err_next;
            pos_reg          <= pos_next;
            run_sum_reg      <= run_sum_next;
        end
    end

    // stage 1: error and window sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (heading.ready)
        begin
            s1_valid_reg <= heading.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_err_reg <= err_next;
            s1_sum_reg <= run_sum_next;
        end
    end

    hpc_shaper u_shaper (
        .err       (s1_err_reg),
        .sum       (s1_sum_reg),
        .cfg       (cfg_reg),
        .turn_rate (turn_next)
    );

    // stage 2: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            turn_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            turn_reg <= turn_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= pos_t'(WIN_LEN - 1))
        else $error("ring position out of range");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (pos_reg == (($past(pos_reg) == pos_t'(WIN_LEN - 1)) ?
                                 pos_t'(0) : $past(pos_reg) + pos_t'(1))))
        else $error("ring position did not advance on accept");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(pos_reg))
        else $error("ring position moved without accept");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        turn_valid_reg |-> (turn_reg != turn_t'(-128)))
        else $error("turn rate outside symmetric range");

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted beat lost in first stage");

endmodule
`default_nettype wire
